@@ src/deq_pkg.sv @@
package deq_pkg;

  // Default sizing of the ring
  localparam int DEQ_DEPTH      = 1024;
  localparam int DEQ_DATA_WIDTH = 32;

  // Fixed port widths
  localparam int MODE_W   = 3;
  localparam int FIELD_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_STATUS     = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH
  } deq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic ins_front;
    logic ins_back;
    logic rem_front;
    logic rem_back;
    logic flag_full;
    logic flag_empty;
    logic finish;
  } deq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
  } deq_stat_t;

endpackage

@@ src/deq_ram.sv @@
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/deq_ctrl.sv @@
module deq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  deq_pkg::deq_stat_t stat,
  output deq_pkg::deq_cmd_t  cmd,
  output logic               busy
);

  import deq_pkg::*;

  deq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = start;
      end
      S_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
        unique case (stat.op)
          OP_PUSH_FRONT: begin
            if (stat.full) cmd.flag_full = 1'b1;
            else           cmd.ins_front = 1'b1;
          end
          OP_PUSH_BACK: begin
            if (stat.full) cmd.flag_full = 1'b1;
            else           cmd.ins_back = 1'b1;
          end
          OP_POP_FRONT: begin
            if (stat.empty) cmd.flag_empty = 1'b1;
            else            cmd.rem_front = 1'b1;
          end
          OP_POP_BACK: begin
            if (stat.empty) cmd.flag_empty = 1'b1;
            else            cmd.rem_back = 1'b1;
          end
          default: ;  // status only, unused codes too
        endcase
      end
      S_FETCH: begin
        busy       = 1'b1;
        cmd.finish = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ src/deq_dp.sv @@
module deq_dp #(
  parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
  parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  deq_pkg::deq_cmd_t                    cmd,
  output deq_pkg::deq_stat_t                   stat,
  input  logic [deq_pkg::MODE_W-1:0]           in_mode,
  input  logic signed [deq_pkg::FIELD_W-1:0]   in_push_value,
  output logic                                 out_strobe,
  output logic signed [deq_pkg::FIELD_W-1:0]   out_popped_value,
  output logic [deq_pkg::STATUS_W-1:0]         out_status,
  output logic [deq_pkg::COUNT_W-1:0]          out_entry_count,
  output logic                                 out_is_empty,
  output logic signed [deq_pkg::FIELD_W-1:0]   out_front_value,
  output logic signed [deq_pkg::FIELD_W-1:0]   out_back_value
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic [DATA_WIDTH-1:0] d);
    logic [XW-1:0] t;
    t = XW'(d);
    return t[FIELD_W-1:0];
  endfunction

  logic [MODE_W-1:0]     mode_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] front_r, front_nxt;
  logic [DATA_WIDTH-1:0] back_r, back_nxt;
  logic [DATA_WIDTH-1:0] popped_r;
  deq_status_t           status_r;
  logic                  refresh_front_r, refresh_back_r;
  logic                  strobe_r;

  logic [DATA_WIDTH-1:0] in_value;
  logic [XW-1:0]         in_wide;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic [DATA_WIDTH-1:0] front_fin, back_fin;
  logic                  now_empty;

  assign in_wide  = XW'($unsigned(in_push_value));
  assign in_value = in_wide[DATA_WIDTH-1:0];

  assign stat.op    = op_t'(mode_r);
  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);

  // Ring pointer, count and cached end values
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    mem_we    = 1'b0;
    mem_waddr = head_r;
    mem_re    = 1'b0;
    mem_raddr = head_r;
    if (cmd.ins_front) begin
      head_nxt  = ring_prev(head_r);
      mem_we    = 1'b1;
      mem_waddr = ring_prev(head_r);
      count_nxt = count_r + 1'b1;
      front_nxt = value_r;
      if (stat.empty) back_nxt = value_r;
    end
    if (cmd.ins_back) begin
      tail_nxt  = ring_next(tail_r);
      mem_we    = 1'b1;
      mem_waddr = tail_r;
      count_nxt = count_r + 1'b1;
      back_nxt  = value_r;
      if (stat.empty) front_nxt = value_r;
    end
    if (cmd.rem_front) begin
      head_nxt  = ring_next(head_r);
      count_nxt = count_r - 1'b1;
      mem_re    = 1'b1;
      mem_raddr = ring_next(head_r);
    end
    if (cmd.rem_back) begin
      tail_nxt  = ring_prev(tail_r);
      count_nxt = count_r - 1'b1;
      mem_re    = 1'b1;
      mem_raddr = ring_prev(ring_prev(tail_r));
    end
    if (cmd.finish) begin
      front_nxt = front_fin;
      back_nxt  = back_fin;
    end
  end

  assign front_fin = refresh_front_r ? mem_rdata : front_r;
  assign back_fin  = refresh_back_r  ? mem_rdata : back_r;
  assign now_empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r          <= '0;
      tail_r          <= '0;
      count_r         <= '0;
      refresh_front_r <= 1'b0;
      refresh_back_r  <= 1'b0;
      strobe_r        <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      strobe_r <= cmd.finish;
      if (cmd.execute) begin
        refresh_front_r <= cmd.rem_front;
        refresh_back_r  <= cmd.rem_back;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    back_r  <= back_nxt;
    if (cmd.capture) begin
      mode_r  <= in_mode;
      value_r <= in_value;
    end
    if (cmd.execute) begin
      popped_r <= cmd.rem_front ? front_r : (cmd.rem_back ? back_r : '0);
      status_r <= cmd.flag_full ? ST_FULL : (cmd.flag_empty ? ST_EMPTY : ST_OK);
    end
    if (cmd.finish) begin
      out_popped_value <= to_field(popped_r);
      out_status       <= status_r;
      out_entry_count  <= COUNT_W'(count_r);
      out_is_empty     <= now_empty;
      out_front_value  <= now_empty ? '0 : to_field(front_fin);
      out_back_value   <= now_empty ? '0 : to_field(back_fin);
    end
  end

  assign out_strobe = strobe_r;

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (value_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ src/double_ended_queue.sv @@
// Channel   Handshake            Word
// --------  -------------------  -----------------------------------------------
// input     start / busy         in_mode, in_push_value
// result    out_strobe (1 cycle) out_popped_value, out_status, out_entry_count,
//                                out_is_empty, out_front_value, out_back_value
//
// Every word passes the accept edge, then an execute state in which the ring
// pointers move and the RAM is written or read, then a fetch state in which
// the RAM's registered read data comes back as the new front or back value.
// out_strobe is high in the cycle after that, and a new word is taken in it.
// Reset (rst_n low, synchronous) empties the ring; RAM contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
  parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [deq_pkg::MODE_W-1:0]           in_mode,
  input  logic signed [deq_pkg::FIELD_W-1:0]   in_push_value,
  output logic                                 out_strobe,
  output logic signed [deq_pkg::FIELD_W-1:0]   out_popped_value,
  output logic [deq_pkg::STATUS_W-1:0]         out_status,
  output logic [deq_pkg::COUNT_W-1:0]          out_entry_count,
  output logic                                 out_is_empty,
  output logic signed [deq_pkg::FIELD_W-1:0]   out_front_value,
  output logic signed [deq_pkg::FIELD_W-1:0]   out_back_value
);

  import deq_pkg::*;

  deq_cmd_t  cmd;
  deq_stat_t stat;

  // Sequence each word: capture, execute, then collect the read data
  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold head, tail, count, the cached end values and the ring RAM
  deq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_mode),
    .in_push_value    (in_push_value),
    .out_strobe       (out_strobe),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value)
  );

  // An accepted word makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // After busy rises, the result strobe follows the execute and fetch states
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> ##2 out_strobe)
    else $error("result strobe missing");

  // The strobe cycle is free to take the next word
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("strobe while busy");

  // An empty ring reports zero front and back values
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_is_empty |-> out_front_value == '0 && out_back_value == '0)
    else $error("empty ring reported nonzero end value");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the double-ended queue.
// Words go in on start/busy; every accepted word owes exactly one reply on
// out_strobe. A shadow ring inside the bench predicts each reply, and the
// scoreboard matches replies to predictions in arrival order.
module tb_top;
  import deq_pkg::*;

  localparam int RING  = DEQ_DEPTH;
  localparam int PTR_W = $clog2(RING);

  // Mode codes the block does not define; they must behave as a status query
  localparam logic [MODE_W-1:0] MODE_RSVD_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [FIELD_W-1:0] popped;
    deq_status_t        status;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic [FIELD_W-1:0] front;
    logic [FIELD_W-1:0] back;
  } deq_reply_t;

  // One row of the directed table: the word to send, and, where the reply is
  // obvious by hand, that reply typed in. Untyped rows use the shadow ring.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] value;
    logic               typed;
    deq_reply_t         reply;
  } dir_row_t;

  localparam int N_DIR = 25;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    // pops and a query on the empty ring right after reset
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 11'd0, 1'b1, 32'h0, 32'h0}},
    '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{32'h0, ST_EMPTY, 11'd0, 1'b1, 32'h0, 32'h0}},
    '{OP_STATUS,     32'h0000_0000, 1'b1, '{32'h0, ST_OK,    11'd0, 1'b1, 32'h0, 32'h0}},
    // extremes of the value, both ends; head wraps below zero on the first front push
    '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1,
      '{32'h0, ST_OK, 11'd1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
    '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1,
      '{32'h0, ST_OK, 11'd2, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF}},
    '{OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b1,
      '{32'h0, ST_OK, 11'd3, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF}},
    '{OP_PUSH_FRONT, 32'h0000_0000, 1'b1,
      '{32'h0, ST_OK, 11'd4, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF}},
    // undefined mode codes and a plain query: nothing moves
    '{MODE_RSVD_5,   32'hDEAD_BEEF, 1'b1,
      '{32'h0, ST_OK, 11'd4, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF}},
    '{MODE_RSVD_6,   32'hFFFF_FFFF, 1'b1,
      '{32'h0, ST_OK, 11'd4, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF}},
    '{MODE_RSVD_7,   32'h0000_0000, 1'b1,
      '{32'h0, ST_OK, 11'd4, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF}},
    '{OP_STATUS,     32'h5A5A_5A5A, 1'b1,
      '{32'h0, ST_OK, 11'd4, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF}},
    // pop a zero off the front, then the all-ones word off the back
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1,
      '{32'h0, ST_OK, 11'd3, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF}},
    '{OP_POP_BACK,   32'h0000_0000, 1'b1,
      '{32'hFFFF_FFFF, ST_OK, 11'd2, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF}},
    // mixed traffic down to empty, checked against the shadow ring
    '{OP_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
    '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
    '{OP_POP_BACK,   32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 11'd0, 1'b1, 32'h0, 32'h0}},
    '{OP_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
    '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h5555_5555, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0},
    '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{OP_STATUS,     32'h0000_0000, 1'b1, '{32'h0, ST_OK, 11'd0, 1'b1, 32'h0, 32'h0}}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [MODE_W-1:0]         in_mode;
  logic signed [FIELD_W-1:0] in_push_value;
  logic                      out_strobe;
  logic signed [FIELD_W-1:0] out_popped_value;
  logic [STATUS_W-1:0]       out_status;
  logic [COUNT_W-1:0]        out_entry_count;
  logic                      out_is_empty;
  logic signed [FIELD_W-1:0] out_front_value;
  logic signed [FIELD_W-1:0] out_back_value;

  // Shadow copy of the ring and its pointers
  logic [FIELD_W-1:0] shadow [RING];
  logic [PTR_W-1:0]   head_ptr;
  logic [PTR_W-1:0]   tail_ptr;
  int                 level;

  // Replies owed by the block, oldest first
  deq_reply_t replies_due [$];

  int mismatches;
  int words_sent;
  int replies_checked;
  int full_drops;
  int empty_pops;
  int ring_fills;

  double_ended_queue u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_push_value    (in_push_value),
    .out_strobe       (out_strobe),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one operation to the shadow ring and return the reply it owes.
  // Full pushes and empty pops leave the ring alone and only flag status.
  function automatic deq_reply_t apply_op(input logic [MODE_W-1:0] mode,
                                          input logic [FIELD_W-1:0] value);
    deq_reply_t       r;
    logic [PTR_W-1:0] last;
    r = '0;
    case (mode) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (level == RING) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          if (mode == OP_PUSH_FRONT) begin
            head_ptr = head_ptr - 1'b1;
            shadow[head_ptr] = value;
          end else begin
            shadow[tail_ptr] = value;
            tail_ptr = tail_ptr + 1'b1;
          end
          level++;
          if (level == RING) ring_fills++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (level == 0) begin
          r.status = ST_EMPTY;
          empty_pops++;
        end else begin
          if (mode == OP_POP_FRONT) begin
            r.popped = shadow[head_ptr];
            head_ptr = head_ptr + 1'b1;
          end else begin
            tail_ptr = tail_ptr - 1'b1;
            r.popped = shadow[tail_ptr];
          end
          level--;
        end
      end
      default: ;  // status query and undefined codes change nothing
    endcase
    r.count = COUNT_W'(level);
    r.empty = (level == 0);
    if (level != 0) begin
      last    = tail_ptr - 1'b1;
      r.front = shadow[head_ptr];
      r.back  = shadow[last];
    end
    return r;
  endfunction

  function automatic logic [MODE_W-1:0] push_side();
    return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
  endfunction

  function automatic logic [MODE_W-1:0] pop_side();
    return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  // Draw an operation; push_pct tilts the ring toward filling or draining.
  function automatic logic [MODE_W-1:0] pick_mode(input int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      case ($urandom_range(2))
        0:       return MODE_RSVD_5;
        1:       return MODE_RSVD_6;
        default: return MODE_RSVD_7;
      endcase
    end
    if (r < 10) return OP_STATUS;
    if ($urandom_range(99) < push_pct) return push_side();
    return pop_side();
  endfunction

  // Favor the sign and all-bits corners, otherwise a full random word
  function automatic logic [FIELD_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Send one word. Drive on the falling edge, hold start and the fields until
  // a rising edge finds busy low, then book the reply it owes. With idle_pct
  // above zero, drop start for a random number of cycles first.
  task automatic run_word(input logic [MODE_W-1:0] mode, input logic [FIELD_W-1:0] value,
                          input int idle_pct, input logic typed, input deq_reply_t want);
    deq_reply_t calc;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_mode       <= mode;
    in_push_value <= value;
    do @(posedge clk); while (busy);
    // Advance the shadow ring even when the reply is typed in by hand
    calc = apply_op(mode, value);
    replies_due = {replies_due, (typed ? want : calc)};
    words_sent++;
  endtask

  // Random traffic in bursts: each burst picks a fill bias and, now and then,
  // runs with no idling at all so gaps and back-to-back words both show up.
  task automatic random_run(input int n_words, input int idle_pct);
    int bias;
    int burst_idle;
    int left;
    left = 0;
    for (int i = 0; i < n_words; i++) begin
      if (left == 0) begin
        left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0:       bias = 25;
          1:       bias = 50;
          default: bias = 80;
        endcase
        burst_idle = ($urandom_range(3) == 0) ? 0 : idle_pct;
      end
      left--;
      run_word(pick_mode(bias), pick_value(), burst_idle, 1'b0, '0);
    end
  endtask

  // Fill the ring to the brim, push more words while full, then mixed traffic.
  task automatic fill_to_full(input int idle_pct);
    while (level < RING) run_word(push_side(), pick_value(), idle_pct, 1'b0, '0);
    repeat (4) run_word(push_side(), pick_value(), idle_pct, 1'b0, '0);
    repeat (12) run_word(pick_mode(60), pick_value(), idle_pct, 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Scoreboard: every strobe must match the oldest reply owed
  always @(posedge clk) begin
    deq_reply_t want;
    if (rst_n && out_strobe) begin
      if (replies_due.size() == 0) begin
        $error("out_strobe with no reply owed");
        mismatches++;
      end else begin
        want = replies_due[0];
        replies_due.delete(0);
        check_field("out_popped_value", want.popped, out_popped_value);
        check_field("out_status",       FIELD_W'(want.status), FIELD_W'(out_status));
        check_field("out_entry_count",  FIELD_W'(want.count),  FIELD_W'(out_entry_count));
        check_field("out_is_empty",     FIELD_W'(want.empty),  FIELD_W'(out_is_empty));
        check_field("out_front_value",  want.front, out_front_value);
        check_field("out_back_value",   want.back,  out_back_value);
        replies_checked++;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_mode         = OP_STATUS;
    in_push_value   = '0;
    head_ptr        = '0;
    tail_ptr        = '0;
    level           = 0;
    mismatches      = 0;
    words_sent      = 0;
    replies_checked = 0;
    full_drops      = 0;
    empty_pops      = 0;
    ring_fills      = 0;

    // Hold reset low, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, back to back
    for (int i = 0; i < N_DIR; i++)
      run_word(DIR_TAB[i].mode, DIR_TAB[i].value, 0, DIR_TAB[i].typed, DIR_TAB[i].reply);

    // Random phases: no idling near empty and up to full, sender mostly idle,
    // no idling again (the result side has no stall to exercise), light
    // sender idling
    random_run(50, 0);
    fill_to_full(0);
    random_run(40, 85);
    random_run(30, 0);
    random_run(40, 20);

    @(negedge clk);
    start <= 1'b0;

    // Let the pipe empty, then wait on to catch stray strobes
    for (int i = 0; i < 2000 && replies_due.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d replies never arrived", replies_due.size());
      mismatches++;
    end

    $display("tb_top: %0d words sent, %0d replies checked, %0d mismatches",
             words_sent, replies_checked, mismatches);
    $display("tb_top: ring filled %0d times, %0d pushes dropped when full, %0d empty pops",
             ring_fills, full_drops, empty_pops);
    if (mismatches == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb_top: timeout, %0d replies still owed", replies_due.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
